>>> src/lzw_pkg.sv
// Shared types and constants of the hashed LZW byte compressor.
// No dependencies; the front end, engine, packer, top and checker import this package.
package lzw_pkg;

    localparam int BYTE_W          = 8;
    localparam int PEND_W          = 7;   // at most seven stream bits wait between codes
    localparam int EPOCH_W         = 8;
    localparam int FIRST_FREE_CODE = 256;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PTR_W           = $clog2(QUEUE_DEPTH);

    // One input beat after classification by the front end.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_block;
        logic              first_of_block;
    } t_q_item;

    // What the packer is asked to do with the codes of one item.
    typedef struct packed {
        logic has_code;   // emit the miss code
        logic eob;        // emit the closing code, then flush the partial byte
    } t_pack_ctl;

endpackage

>>> src/lzw_in_if.sv
// Input channel of the compressor: one uncompressed byte per beat.
// Depends on nothing.
interface lzw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_block;

    modport source (output valid, output data_byte, output end_of_block, input ready);
    modport sink   (input valid, input data_byte, input end_of_block, output ready);
endinterface

>>> src/lzw_out_if.sv
// Output channel of the compressor: one byte of the packed code stream per beat.
// Depends on nothing.
interface lzw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last_of_run;
    logic       last_of_block;

    modport source (output valid, output packed_byte, output last_of_run,
                    output last_of_block, input ready);
    modport sink   (input valid, input packed_byte, input last_of_run,
                    input last_of_block, output ready);
endinterface

>>> src/lzw_front.sv
// Front end: accepts input beats, tags the first byte of each block and
// queues them for the dictionary engine. Depends on lzw_pkg and lzw_in_if.
module lzw_front import lzw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lzw_in_if.sink  i_in,
    input  logic    i_hold,
    output logic    o_q_valid,
    output t_q_item o_q_item,
    input  logic    i_q_pop
);

    t_q_item          r_q [QUEUE_DEPTH];
    logic [PTR_W:0]   r_wptr;
    logic [PTR_W:0]   r_rptr;
    logic             r_block_open;
    logic             w_full;
    logic             w_push;

    assign w_full = (r_wptr[PTR_W] != r_rptr[PTR_W]) &&
                    (r_wptr[PTR_W-1:0] == r_rptr[PTR_W-1:0]);

    // Nothing is taken while the engine sweeps the dictionary.
    assign i_in.ready = !w_full && !i_hold;
    assign w_push     = i_in.valid && i_in.ready;

    assign o_q_valid = (r_wptr != r_rptr);
    assign o_q_item  = r_q[r_rptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr       <= '0;
            r_rptr       <= '0;
            r_block_open <= 1'b0;
        end else begin
            if (w_push) begin
                r_wptr       <= r_wptr + (PTR_W+1)'(1);
                r_block_open <= !i_in.end_of_block;
            end
            if (i_q_pop) begin
                r_rptr <= r_rptr + (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr[PTR_W-1:0]] <= '{data_byte:      i_in.data_byte,
                                        end_of_block:   i_in.end_of_block,
                                        first_of_block: !r_block_open};
        end
    end

endmodule

>>> src/lzw_dict.sv
// Dictionary engine: hashed, linearly probed string table held in one memory,
// with an epoch mark per entry in place of valid bits. Depends on lzw_pkg.
module lzw_dict import lzw_pkg::*; #(
    parameter int CODE_BITS    = 12,
    parameter int HASH_ENTRIES = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_q_item              i_q_item,
    output logic                 o_q_pop,
    output logic                 o_hold,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output logic [CODE_BITS-1:0] o_code1,
    output logic [CODE_BITS-1:0] o_code2,
    output t_pack_ctl            o_ctl
);

    localparam int IDX_W  = $clog2(HASH_ENTRIES);
    localparam int KEY_W  = CODE_BITS + BYTE_W;
    localparam int WORD_W = EPOCH_W + KEY_W + CODE_BITS;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    logic [WORD_W-1:0]    r_mem [HASH_ENTRIES];
    logic [WORD_W-1:0]    r_rdata;

    logic [1:0]           r_state, n_state;
    logic [CODE_BITS-1:0] r_cur, n_cur;
    logic [CODE_BITS:0]   r_nfc, n_nfc;
    logic [EPOCH_W-1:0]   r_epoch, n_epoch;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_probes, n_probes;
    logic [IDX_W-1:0]     r_clr, n_clr;
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic                 r_last, n_last;
    logic                 r_cmd_valid, n_cmd_valid;
    logic [CODE_BITS-1:0] r_code1, n_code1;
    logic [CODE_BITS-1:0] r_code2, n_code2;
    t_pack_ctl            r_ctl, n_ctl;

    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [WORD_W-1:0]    w_wdata;
    logic [IDX_W-1:0]     w_raddr;
    logic                 w_finish;

    logic [31:0]          w_p32;
    logic [31:0]          w_h32;
    logic [IDX_W-1:0]     w_hash;

    logic [CODE_BITS-1:0] w_ent_code;
    logic [KEY_W-1:0]     w_ent_key;
    logic [EPOCH_W-1:0]   w_ent_epoch;
    logic                 w_ent_live;
    logic                 w_ent_hit;

    // Hash of (current code, new byte); the table size is a power of two.
    assign w_p32  = 32'(r_cur);
    assign w_h32  = (w_p32 << 5) ^ 32'(i_q_item.data_byte) ^ (w_p32 >> 3);
    assign w_hash = w_h32[IDX_W-1:0];

    assign w_ent_code  = r_rdata[CODE_BITS-1:0];
    assign w_ent_key   = r_rdata[CODE_BITS +: KEY_W];
    assign w_ent_epoch = r_rdata[CODE_BITS+KEY_W +: EPOCH_W];
    // An entry written in an earlier block carries an older epoch and reads as empty.
    assign w_ent_live  = (w_ent_epoch == r_epoch);
    assign w_ent_hit   = w_ent_live && (w_ent_key == {r_cur, r_byte});

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_nfc       = r_nfc;
        n_epoch     = r_epoch;
        n_idx       = r_idx;
        n_probes    = r_probes;
        n_clr       = r_clr;
        n_byte      = r_byte;
        n_last      = r_last;
        n_cmd_valid = r_cmd_valid && !i_cmd_ready;
        n_code1     = r_code1;
        n_code2     = r_code2;
        n_ctl       = r_ctl;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = {r_epoch, r_cur, r_byte, r_nfc[CODE_BITS-1:0]};
        w_raddr     = w_hash;
        w_finish    = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + IDX_W'(1);
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // The command slot must be free so that this item can always post its codes.
                if (i_q_valid && !r_cmd_valid) begin
                    o_q_pop = 1'b1;
                    n_byte  = i_q_item.data_byte;
                    n_last  = i_q_item.end_of_block;
                    if (i_q_item.first_of_block) begin
                        n_cur = CODE_BITS'(i_q_item.data_byte);
                        n_nfc = (CODE_BITS+1)'(FIRST_FREE_CODE);
                        if (i_q_item.end_of_block) begin
                            n_cmd_valid = 1'b1;
                            n_code2     = CODE_BITS'(i_q_item.data_byte);
                            n_ctl       = '{has_code: 1'b0, eob: 1'b1};
                            w_finish    = 1'b1;
                        end
                    end else begin
                        n_idx    = w_hash;
                        n_probes = '0;
                        n_state  = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                w_raddr = r_idx + IDX_W'(1);
                if (w_ent_hit) begin
                    n_cur   = w_ent_code;
                    n_state = ST_IDLE;
                    if (r_last) begin
                        n_cmd_valid = 1'b1;
                        n_code2     = w_ent_code;
                        n_ctl       = '{has_code: 1'b0, eob: 1'b1};
                        w_finish    = 1'b1;
                    end
                end else if (w_ent_live && (r_probes != '1)) begin
                    n_idx    = r_idx + IDX_W'(1);
                    n_probes = r_probes + IDX_W'(1);
                end else begin
                    // Miss. An empty slot is where the pair goes; a full table or code space takes nothing.
                    if (!w_ent_live && !r_nfc[CODE_BITS]) begin
                        w_we  = 1'b1;
                        n_nfc = r_nfc + (CODE_BITS+1)'(1);
                    end
                    n_cur       = CODE_BITS'(r_byte);
                    n_state     = ST_IDLE;
                    n_cmd_valid = 1'b1;
                    n_code1     = r_cur;
                    n_code2     = CODE_BITS'(r_byte);
                    n_ctl       = '{has_code: 1'b1, eob: r_last};
                    w_finish    = r_last;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A new epoch per block; when the mark runs out the table is swept first.
        if (w_finish) begin
            if (r_epoch == '1) begin
                n_epoch = EPOCH_W'(1);
                n_clr   = '0;
                n_state = ST_CLEAR;
            end else begin
                n_epoch = r_epoch + EPOCH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_epoch     <= EPOCH_W'(1);
            r_cur       <= '0;
            r_nfc       <= (CODE_BITS+1)'(FIRST_FREE_CODE);
            r_cmd_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_epoch     <= n_epoch;
            r_cur       <= n_cur;
            r_nfc       <= n_nfc;
            r_cmd_valid <= n_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_probes <= n_probes;
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_code1  <= n_code1;
        r_code2  <= n_code2;
        r_ctl    <= n_ctl;
    end

    assign o_hold      = (r_state == ST_CLEAR);
    assign o_cmd_valid = r_cmd_valid;
    assign o_code1     = r_code1;
    assign o_code2     = r_code2;
    assign o_ctl       = r_ctl;

endmodule

>>> src/lzw_pack.sv
// Back end: packs codes LSB first into bytes and drives the output register.
// Depends on lzw_pkg and lzw_out_if.
module lzw_pack import lzw_pkg::*; #(
    parameter int CODE_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  logic [CODE_BITS-1:0] i_code1,
    input  logic [CODE_BITS-1:0] i_code2,
    input  t_pack_ctl            i_ctl,
    lzw_out_if.source            o_out
);

    localparam int ACC_W = PEND_W + 2 * CODE_BITS;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic                 r_busy;
    logic [ACC_W-1:0]     r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_eob;
    logic [PEND_W-1:0]    r_pend;
    logic [2:0]           r_pcnt;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_run;
    logic                 r_out_blk;

    logic                 w_load;
    logic                 w_emit;
    logic                 w_done;
    logic [CNT_W-1:0]     w_sh2;
    logic [ACC_W-1:0]     w_acc;
    logic [CNT_W-1:0]     w_cnt;

    assign o_cmd_ready = !r_busy;
    assign w_load      = i_cmd_valid && !r_busy;

    // The waiting bits, then the miss code, then the closing code, all LSB first.
    assign w_sh2 = CNT_W'(r_pcnt) + (i_ctl.has_code ? CNT_W'(CODE_BITS) : '0);
    assign w_cnt = w_sh2 + (i_ctl.eob ? CNT_W'(CODE_BITS) : '0);
    assign w_acc = ACC_W'(r_pend)
                 | (i_ctl.has_code ? (ACC_W'(i_code1) << r_pcnt) : '0)
                 | (i_ctl.eob      ? (ACC_W'(i_code2) << w_sh2)  : '0);

    assign w_emit = r_busy && (!r_out_valid || o_out.ready);
    // At block end the partial byte goes out too, with its high bits zero.
    assign w_done = r_eob ? (r_cnt <= CNT_W'(8)) : (r_cnt < CNT_W'(16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= '0;
            r_pcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_done) begin
                r_busy <= 1'b0;
                if (r_eob) begin
                    r_pend <= '0;
                    r_pcnt <= '0;
                end else begin
                    r_pend <= r_acc[BYTE_W +: PEND_W];
                    r_pcnt <= r_cnt[2:0];
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_acc <= w_acc;
            r_cnt <= w_cnt;
            r_eob <= i_ctl.eob;
        end else if (w_emit) begin
            r_acc <= r_acc >> BYTE_W;
            r_cnt <= r_cnt - CNT_W'(8);
        end
        if (w_emit) begin
            r_out_byte <= r_acc[BYTE_W-1:0];
            r_out_run  <= w_done;
            r_out_blk  <= w_done && r_eob;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.packed_byte   = r_out_byte;
    assign o_out.last_of_run   = r_out_run;
    assign o_out.last_of_block = r_out_blk;

endmodule

>>> src/lzw12_hashed_byte_compressor_top.sv
// Block-wise LZW byte compressor with fixed-width codes and a hashed dictionary.
// Depends on lzw_pkg, lzw_in_if, lzw_out_if, lzw_front, lzw_dict and lzw_pack.
//
// Usage: bytes enter on i_in, one per beat, with end_of_block on the last byte of
// a block. Packed code-stream bytes leave on o_out; last_of_run marks the final
// byte caused by one input beat and last_of_block the final byte of a block.
// A byte that extends a match produces no output beat, unless it ends a block.
// The front end queues two beats between the input and the dictionary engine.
// Flow: a byte that needs a table probe passes the engine's idle state, then
// its probe state once per probe of a collision chain. A code is packed one
// output byte per cycle while the receiver takes bytes, after its load into
// the accumulator; the packer takes no new item until its last byte is emitted.
// A byte passes the queue, engine, command, accumulator and output registers.
// Reset: i_rst_n is synchronous and active low. After reset the engine sweeps
// the whole table, all HASH_ENTRIES entries, with i_in.ready low; the same sweep
// repeats after every 255 blocks when the per-block epoch mark wraps.
// A stalled receiver holds the current output byte; the queue then fills and
// i_in.ready drops.
module lzw12_hashed_byte_compressor_top import lzw_pkg::*; #(
    parameter int CODE_BITS    = 12,
    parameter int HASH_ENTRIES = 8192
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lzw_in_if.sink    i_in,
    lzw_out_if.source o_out
);

    logic                 w_hold;
    logic                 w_q_valid;
    t_q_item              w_q_item;
    logic                 w_q_pop;
    logic                 w_cmd_valid;
    logic                 w_cmd_ready;
    logic [CODE_BITS-1:0] w_code1;
    logic [CODE_BITS-1:0] w_code2;
    t_pack_ctl            w_ctl;

    lzw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_hold    (w_hold),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    lzw_dict #(
        .CODE_BITS    (CODE_BITS),
        .HASH_ENTRIES (HASH_ENTRIES)
    ) u_dict (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_hold      (w_hold),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_code1     (w_code1),
        .o_code2     (w_code2),
        .o_ctl       (w_ctl)
    );

    lzw_pack #(
        .CODE_BITS (CODE_BITS)
    ) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_code1     (w_code1),
        .i_code2     (w_code2),
        .i_ctl       (w_ctl),
        .o_out       (o_out)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_no_input_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hold |-> !i_in.ready)
        else $error("input taken during table sweep");

    a_packer_takes_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready) |=> !w_cmd_ready)
        else $error("packer free right after taking a command");

    a_block_end_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_of_block) |-> o_out.last_of_run)
        else $error("block end not on the last byte of its run");

endmodule

>>> dv/lzw12_hashed_byte_compressor_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the hashed LZW byte compressor: watches both channels and predicts
// the packed stream. Depends on lzw_pkg, lzw_in_if and lzw_out_if.
module lzw12_hashed_byte_compressor_checker import lzw_pkg::*; #(
    parameter int CODE_BITS  = 12,
    parameter int TABLE_SIZE = 8192
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lzw_in_if    i_in_mon,
    lzw_out_if   i_out_mon,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam int CODE_LIMIT = (1 << CODE_BITS) - 1;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              last_of_run;
        logic              last_of_block;
    } t_out_beat;

    // Dictionary image, cleared at the start of every block.
    bit                      tbl_used [TABLE_SIZE];
    bit [CODE_BITS+BYTE_W-1:0] tbl_key [TABLE_SIZE];
    bit [CODE_BITS-1:0]      tbl_code [TABLE_SIZE];

    bit [CODE_BITS-1:0] cur_code;
    bit [CODE_BITS:0]   free_code;
    bit                 in_block;
    bit [31:0]          carry_bits;
    int                 carry_cnt;
    int                 item_beats;

    t_out_beat packed_stream_q[$];

    // Probes the chain of (prefix, ch) and returns the slot that holds the pair or the
    // first empty slot of the chain; -1 only if the whole table is occupied.
    function automatic int find_slot(input bit [CODE_BITS-1:0] prefix, input bit [7:0] ch);
        bit [CODE_BITS+BYTE_W-1:0] key;
        int start;
        int slot;
        key   = {prefix, ch};
        start = ((int'(prefix) << 5) ^ int'(ch) ^ (int'(prefix) >> 3)) & (TABLE_SIZE - 1);
        for (int i = 0; i < TABLE_SIZE; i++) begin
            slot = (start + i) & (TABLE_SIZE - 1);
            if (!tbl_used[slot] || tbl_key[slot] == key)
                return slot;
        end
        return -1;
    endfunction

    task automatic emit_code(input bit [CODE_BITS-1:0] code);
        bit [31:0] acc;
        int        cnt;
        acc = carry_bits | (32'(code) << carry_cnt);
        cnt = carry_cnt + CODE_BITS;
        while (cnt >= BYTE_W) begin
            packed_stream_q.push_back('{packed_byte: acc[7:0], last_of_run: 1'b0,
                                        last_of_block: 1'b0});
            item_beats++;
            acc = acc >> BYTE_W;
            cnt -= BYTE_W;
        end
        carry_bits = acc;
        carry_cnt  = cnt;
    endtask

    task automatic encode_byte(input bit [7:0] ch, input bit eob);
        int        slot;
        t_out_beat tail;
        item_beats = 0;
        if (!in_block) begin
            for (int i = 0; i < TABLE_SIZE; i++)
                tbl_used[i] = 1'b0;
            free_code  = (CODE_BITS+1)'(FIRST_FREE_CODE);
            carry_bits = '0;
            carry_cnt  = 0;
            cur_code   = CODE_BITS'(ch);
            in_block   = 1'b1;
        end else begin
            slot = find_slot(cur_code, ch);
            if (slot >= 0 && tbl_used[slot]) begin
                cur_code = tbl_code[slot];
            end else begin
                emit_code(cur_code);
                // Once the code space is exhausted the dictionary is frozen.
                if (free_code <= CODE_LIMIT && slot >= 0) begin
                    tbl_used[slot] = 1'b1;
                    tbl_key[slot]  = {cur_code, ch};
                    tbl_code[slot] = free_code[CODE_BITS-1:0];
                end
                if (free_code <= CODE_LIMIT)
                    free_code++;
                cur_code = CODE_BITS'(ch);
            end
        end
        if (eob) begin
            emit_code(cur_code);
            if (carry_cnt != 0) begin
                packed_stream_q.push_back('{packed_byte: carry_bits[7:0], last_of_run: 1'b0,
                                            last_of_block: 1'b0});
                item_beats++;
            end
            carry_bits = '0;
            carry_cnt  = 0;
            in_block   = 1'b0;
        end
        if (item_beats > 0) begin
            tail = packed_stream_q.pop_back();
            tail.last_of_run   = 1'b1;
            tail.last_of_block = eob;
            packed_stream_q.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_beat want;
        t_out_beat got;
        if (!i_rst_n) begin
            packed_stream_q.delete();
            in_block     = 1'b0;
            free_code    = (CODE_BITS+1)'(FIRST_FREE_CODE);
            cur_code     = '0;
            carry_bits   = '0;
            carry_cnt    = 0;
            o_mismatches = 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                encode_byte(i_in_mon.data_byte, i_in_mon.end_of_block);
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{packed_byte: i_out_mon.packed_byte, last_of_run: i_out_mon.last_of_run,
                        last_of_block: i_out_mon.last_of_block};
                if (packed_stream_q.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected beat: expected none, got %02h run %0b block %0b",
                             $time, got.packed_byte, got.last_of_run, got.last_of_block);
                end else begin
                    want = packed_stream_q.pop_front();
                    if (got.packed_byte !== want.packed_byte
                        || got.last_of_run !== want.last_of_run
                        || got.last_of_block !== want.last_of_block) begin
                        o_mismatches++;
                        $display("%0t: expected %02h run %0b block %0b, got %02h run %0b block %0b",
                                 $time, want.packed_byte, want.last_of_run, want.last_of_block,
                                 got.packed_byte, got.last_of_run, got.last_of_block);
                    end
                end
            end
        end
        o_outstanding = packed_stream_q.size();
    end

endmodule

>>> dv/lzw12_hashed_byte_compressor_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the hashed LZW byte compressor: clock, reset, byte stimulus and verdict.
// Depends on lzw_pkg, lzw_in_if, lzw_out_if, the compressor and its checker.
module lzw12_hashed_byte_compressor_top_test;

    typedef enum {BLK_TEXT, BLK_NOISE, BLK_RUN} t_blk_kind;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    bit   src_idle_en;
    bit   sink_idle_en;
    int   items_sent;
    int   blocks_sent;

    lzw_in_if  in_ch();
    lzw_out_if out_ch();

    lzw12_hashed_byte_compressor_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lzw12_hashed_byte_compressor_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: stalls in bursts while sink_idle_en is set.
    initial begin : sink_stalls
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && sink_idle_en && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 9);
            out_ch.ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic eob);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.end_of_block <= eob;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (eob)
            blocks_sent++;
    endtask

    // Holds the sender back until every predicted beat has left the block.
    task automatic wait_stream_empty();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    task automatic send_block(input int len, input t_blk_kind kind);
        bit [7:0] base;
        bit [7:0] span;
        bit [7:0] b;
        base = 8'($urandom_range(0, 255));
        span = ($urandom_range(0, 1) == 0) ? 8'h03 : 8'($urandom_range(1, 15));
        for (int i = 0; i < len; i++) begin
            case (kind)
                BLK_TEXT:  b = base ^ (8'($urandom_range(0, 255)) & span);
                BLK_NOISE: b = 8'($urandom_range(0, 255));
                default:   b = base;
            endcase
            push_byte(b, i == len - 1);
        end
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.end_of_block = 1'b0;
        i_rst_n            = 1'b0;
        src_idle_en        = 1'b1;
        sink_idle_en       = 1'b1;
        items_sent         = 0;
        blocks_sent        = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single-byte blocks at both extremes of the byte.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        // A run of one byte: some later bytes extend matches and give no beats.
        repeat (4) push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b1);
        for (int i = 0; i < 6; i++)
            push_byte(i[0] ? 8'hFF : 8'h00, i == 5);
        // Two codes fill whole bytes; three codes leave half a byte to flush.
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);
        // The final byte of this block is a dictionary hit.
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b1);
        wait_stream_empty();

        while (items_sent < 60) begin
            src_idle_en  = $urandom_range(0, 3) != 0;
            sink_idle_en = $urandom_range(0, 3) != 0;
            send_block(($urandom_range(0, 4) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(1, 12),
                       t_blk_kind'($urandom_range(0, 9) < 7 ? BLK_TEXT
                                   : ($urandom_range(0, 1) ? BLK_NOISE : BLK_RUN)));
            if ($urandom_range(0, 7) == 0)
                wait_stream_empty();
        end

        // Single-byte blocks bring the per-block epoch close to its wrap.
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        while (blocks_sent < 240)
            send_block(1, BLK_NOISE);

        // Short blocks without idling carry the run past the block-count wrap.
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (blocks_sent < 258)
            send_block($urandom_range(1, 2), t_blk_kind'($urandom_range(0, 2)));

        wait_stream_empty();
        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> lzw12_hashed_byte_compressor_top.f
src/lzw_pkg.sv
src/lzw_in_if.sv
src/lzw_out_if.sv
src/lzw_front.sv
src/lzw_dict.sv
src/lzw_pack.sv
src/lzw12_hashed_byte_compressor_top.sv
dv/lzw12_hashed_byte_compressor_checker.sv
dv/lzw12_hashed_byte_compressor_top_test.sv
